// ===== src/bpmaf_pkg.sv =====
`default_nettype none

package bpmaf_pkg;

    localparam int SAMPLE_W = 8;
    localparam int SUM_W = 10;
    localparam int FILL_W = 2;
    localparam int COUNT_W = 3;

    localparam logic [FILL_W-1:0] FILL_LAST = 2'd2;
    localparam logic [COUNT_W-1:0] MEDIAN_LAST = 3'd3;

    localparam logic [SAMPLE_W-1:0] SYS_LOW_RST = 8'd100;
    localparam logic [SAMPLE_W-1:0] SYS_HIGH_RST = 8'd140;
    localparam logic [SAMPLE_W-1:0] DIA_LOW_RST = 8'd70;
    localparam logic [SAMPLE_W-1:0] DIA_HIGH_RST = 8'd100;

    // floor(x/3) == (x*683) >> 11 for x below 2048
    localparam int WEIGHTED_W = 10;
    localparam int DIV3_SHIFT = 11;
    localparam logic [WEIGHTED_W-1:0] DIV3_MUL = 10'd683;
    localparam int PROD_W = 2 * WEIGHTED_W;

    typedef enum logic [1:0] {
        CFG_SYS_LOW  = 2'd0,
        CFG_SYS_HIGH = 2'd1,
        CFG_DIA_LOW  = 2'd2,
        CFG_DIA_HIGH = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [SAMPLE_W-1:0] low;
        logic [SAMPLE_W-1:0] high;
    } t_bounds;

    typedef struct packed {
        logic [SAMPLE_W-1:0] systolic_sample;
        logic [SAMPLE_W-1:0] diastolic_sample;
        logic [SAMPLE_W-1:0] heart_rate;
        logic [SAMPLE_W-1:0] oxygen_saturation;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] systolic_result;
        logic [SAMPLE_W-1:0] diastolic_result;
        logic [SAMPLE_W-1:0] mean_pressure;
    } t_out_item;

    function automatic logic [SAMPLE_W-1:0] median3(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b,
        input logic [SAMPLE_W-1:0] c
    );
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        logic [SAMPLE_W-1:0] mid;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        mid = (hi < c) ? hi : c;
        return (lo > mid) ? lo : mid;
    endfunction

endpackage

`default_nettype wire

// ===== src/bpmaf_channel.sv =====
`default_nettype none

module bpmaf_channel (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_take,
    input  wire logic [bpmaf_pkg::SAMPLE_W-1:0]    i_sample,
    input  wire bpmaf_pkg::t_bounds                i_bounds,
    output logic      [bpmaf_pkg::SAMPLE_W-1:0]    o_average
);
    import bpmaf_pkg::*;

    // third entry is consumed on the cycle it arrives, so only two are held
    logic [SAMPLE_W-1:0] r_window [2];
    logic [FILL_W-1:0]   r_fill;
    logic [COUNT_W-1:0]  r_count;
    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] r_average;

    logic                w_load;
    logic                w_full;
    logic [SAMPLE_W-1:0] w_median;
    logic [SUM_W-1:0]    n_sum;

    assign w_load = i_take && (i_sample >= i_bounds.low) && (i_sample <= i_bounds.high);
    assign w_full = (r_fill == FILL_LAST);
    assign w_median = median3(r_window[0], r_window[1], i_sample);
    assign n_sum = r_sum + SUM_W'(w_median);
    assign o_average = r_average;

    always_ff @(posedge i_clk) begin
        if (w_load && !w_full) begin
            r_window[r_fill[0]] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_average <= '0;
        end else if (w_load) begin
            if (w_full) begin
                r_fill <= '0;
                if (r_count == MEDIAN_LAST) begin
                    r_average <= n_sum[SUM_W-1:2];
                    r_sum     <= '0;
                    r_count   <= '0;
                end else begin
                    r_sum   <= n_sum;
                    r_count <= r_count + COUNT_W'(1);
                end
            end else begin
                r_fill <= r_fill + FILL_W'(1);
            end
        end
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != 2'd3)
        else $error("window fill out of range");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MEDIAN_LAST)
        else $error("median count out of range");

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_full && r_count == MEDIAN_LAST) |=> (r_count == '0 && r_sum == '0))
        else $error("sum not cleared after fourth median");

endmodule

`default_nettype wire

// ===== src/bpmaf_out_stage.sv =====
`default_nettype none

module bpmaf_out_stage (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic [bpmaf_pkg::SAMPLE_W-1:0]    i_sys_avg,
    input  wire logic [bpmaf_pkg::SAMPLE_W-1:0]    i_dia_avg,
    input  wire logic                              i_no_signal,
    output bpmaf_pkg::t_out_item                   o_result
);
    import bpmaf_pkg::*;

    t_out_item             r_result;
    logic [WEIGHTED_W-1:0] w_weighted;
    logic [PROD_W-1:0]     w_prod;

    assign w_weighted = WEIGHTED_W'({i_dia_avg, 1'b0}) + WEIGHTED_W'(i_sys_avg);
    assign w_prod = PROD_W'(w_weighted) * PROD_W'(DIV3_MUL);
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result.systolic_result  <= i_sys_avg;
            r_result.diastolic_result <= i_dia_avg;
            r_result.mean_pressure    <= i_no_signal ? '0 : w_prod[DIV3_SHIFT +: SAMPLE_W];
        end
    end

endmodule

`default_nettype wire

// ===== src/blood_pressure_median_average_filter.sv =====
// Three register stages: the input register, the channel averages, the output.
// Throughput: one transaction per cycle; the whole pipeline stalls only
// while a result waits at the output.
// Config writes take effect at once; the config port is ready out of reset.
// Reset (synchronous, active low) empties the pipeline, holds both readies low,
// restores default acceptance windows and zeroes channel counters, sums, averages.
`default_nettype none

module blood_pressure_median_average_filter (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire bpmaf_pkg::t_in_item               i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output bpmaf_pkg::t_out_item                   o_out_data,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire bpmaf_pkg::t_cfg_index             i_cfg_index,
    input  wire logic [bpmaf_pkg::SAMPLE_W-1:0]    i_cfg_data
);
    import bpmaf_pkg::*;

    logic      r_v1;
    logic      r_v2;
    logic      r_v3;
    t_in_item  r_in;
    logic      r_no_signal;
    t_bounds   r_sys_bounds;
    t_bounds   r_dia_bounds;

    logic                w_advance;
    logic                w_take;
    logic [SAMPLE_W-1:0] w_sys_avg;
    logic [SAMPLE_W-1:0] w_dia_avg;

    assign w_advance = !r_v3 || i_out_ready;
    assign w_take = w_advance && r_v1;
    assign o_in_ready = w_advance && i_rst_n;
    assign o_out_valid = r_v3;
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_sys_bounds <= '{low: SYS_LOW_RST, high: SYS_HIGH_RST};
            r_dia_bounds <= '{low: DIA_LOW_RST, high: DIA_HIGH_RST};
        end else begin
            if (w_advance) begin
                r_v1 <= i_in_valid;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SYS_LOW:  r_sys_bounds.low  <= i_cfg_data;
                    CFG_SYS_HIGH: r_sys_bounds.high <= i_cfg_data;
                    CFG_DIA_LOW:  r_dia_bounds.low  <= i_cfg_data;
                    CFG_DIA_HIGH: r_dia_bounds.high <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_in <= i_in_data;
            r_no_signal <= (r_in.heart_rate == '0) && (r_in.oxygen_saturation == '0);
        end
    end

    bpmaf_channel u_sys (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_take),
        .i_sample  (r_in.systolic_sample),
        .i_bounds  (r_sys_bounds),
        .o_average (w_sys_avg)
    );

    bpmaf_channel u_dia (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_take),
        .i_sample  (r_in.diastolic_sample),
        .i_bounds  (r_dia_bounds),
        .o_average (w_dia_avg)
    );

    bpmaf_out_stage u_out (
        .i_clk       (i_clk),
        .i_en        (w_advance),
        .i_sys_avg   (w_sys_avg),
        .i_dia_avg   (w_dia_avg),
        .i_no_signal (r_no_signal),
        .o_result    (o_out_data)
    );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none

module tb_top;
    import bpmaf_pkg::*;

    typedef struct packed {
        logic [2:0][SAMPLE_W-1:0] win;
        logic [FILL_W-1:0]        fill;
        logic [COUNT_W-1:0]       medians;
        logic [SUM_W-1:0]         sum;
        logic [SAMPLE_W-1:0]      avg;
    } t_chan;

    logic          i_clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    t_in_item      in_data = '0;
    logic          out_ready = 1'b0;
    logic          cfg_valid = 1'b0;
    t_cfg_index    cfg_index = CFG_SYS_LOW;
    logic [7:0]    cfg_data = '0;
    logic          o_in_ready;
    logic          o_out_valid;
    t_out_item     o_out_data;
    logic          o_cfg_ready;

    t_out_item     expected_readings[$];
    t_out_item     want_item;
    t_chan         sys_ch;
    t_chan         dia_ch;
    t_bounds       sys_bounds;
    t_bounds       dia_bounds;
    int            mismatches = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            stall_left = 0;
    logic          stall_req = 1'b0;
    logic          stall_seen = 1'b0;

    blood_pressure_median_average_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // receiver: random idling, or a long hold-off while stall_left runs down
    always @(posedge i_clk) begin
        if (stall_req != stall_seen) begin
            stall_seen <= stall_req;
            stall_left <= 150;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            if (expected_readings.size() == 0) begin
                report_mismatch("result with no transaction outstanding",
                                o_out_data.mean_pressure, 0);
            end else begin
                want_item = expected_readings.pop_front();
                if (o_out_data.systolic_result !== want_item.systolic_result)
                    report_mismatch("systolic_result", o_out_data.systolic_result,
                                    want_item.systolic_result);
                if (o_out_data.diastolic_result !== want_item.diastolic_result)
                    report_mismatch("diastolic_result", o_out_data.diastolic_result,
                                    want_item.diastolic_result);
                if (o_out_data.mean_pressure !== want_item.mean_pressure)
                    report_mismatch("mean_pressure", o_out_data.mean_pressure,
                                    want_item.mean_pressure);
            end
        end
    end

    function automatic void feed_channel(inout t_chan ch, input logic [7:0] sample,
                                         input t_bounds b);
        logic [7:0] x0;
        logic [7:0] x1;
        logic [7:0] x2;
        logic [7:0] mid;
        if (sample < b.low || sample > b.high)
            return;
        ch.win[ch.fill] = sample;
        if (ch.fill == 2'd2) begin
            x0 = ch.win[0];
            x1 = ch.win[1];
            x2 = ch.win[2];
            if ((x0 >= x1 && x0 <= x2) || (x0 <= x1 && x0 >= x2))
                mid = x0;
            else if ((x1 >= x0 && x1 <= x2) || (x1 <= x0 && x1 >= x2))
                mid = x1;
            else
                mid = x2;
            ch.fill = '0;
            ch.sum = ch.sum + SUM_W'(mid);
            ch.medians = ch.medians + 3'd1;
        end else begin
            ch.fill = ch.fill + 2'd1;
        end
        if (ch.medians == 3'd4) begin
            ch.avg = ch.sum[9:2];
            ch.sum = '0;
            ch.medians = '0;
        end
    endfunction

    function automatic void filter_reading(input t_in_item item);
        int weighted;
        t_out_item r;
        feed_channel(sys_ch, item.systolic_sample, sys_bounds);
        feed_channel(dia_ch, item.diastolic_sample, dia_bounds);
        weighted = 2 * int'(dia_ch.avg) + int'(sys_ch.avg);
        r.systolic_result = sys_ch.avg;
        r.diastolic_result = dia_ch.avg;
        if (item.heart_rate == '0 && item.oxygen_saturation == '0)
            r.mean_pressure = '0;
        else
            r.mean_pressure = 8'(weighted / 3);
        expected_readings.push_back(r);
    endfunction

    task automatic send_item(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge i_clk); while (!o_in_ready);
        filter_reading(item);
    endtask

    task automatic send_fields(input logic [7:0] sys, input logic [7:0] dia,
                               input logic [7:0] hr, input logic [7:0] spo2);
        t_in_item item;
        item.systolic_sample = sys;
        item.diastolic_sample = dia;
        item.heart_rate = hr;
        item.oxygen_saturation = spo2;
        send_item(item);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SYS_LOW:  sys_bounds.low = value;
            CFG_SYS_HIGH: sys_bounds.high = value;
            CFG_DIA_LOW:  dia_bounds.low = value;
            CFG_DIA_HIGH: dia_bounds.high = value;
            default: ;
        endcase
    endtask

    task automatic set_windows(input logic [7:0] sl, input logic [7:0] sh,
                               input logic [7:0] dl, input logic [7:0] dh);
        wait_drained();
        write_reg(CFG_SYS_LOW, sl);
        write_reg(CFG_SYS_HIGH, sh);
        write_reg(CFG_DIA_LOW, dl);
        write_reg(CFG_DIA_HIGH, dh);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_sample(input t_bounds b);
        if (b.low <= b.high && $urandom_range(99) < 85)
            return 8'($urandom_range(b.high, b.low));
        return 8'($urandom_range(255));
    endfunction

    function automatic t_bounds pick_bounds();
        t_bounds b;
        int a;
        int c;
        case ($urandom_range(9))
            0: begin
                b.low = 8'd0;
                b.high = 8'd255;
            end
            1: begin
                b.low = 8'($urandom_range(255, 1));
                b.high = 8'($urandom_range(int'(b.low) - 1));
            end
            2: begin
                b.low = 8'($urandom_range(255));
                b.high = b.low;
            end
            default: begin
                a = $urandom_range(255);
                c = $urandom_range(255);
                b.low = 8'((a < c) ? a : c);
                b.high = 8'((a < c) ? c : a);
            end
        endcase
        return b;
    endfunction

    task automatic send_random_item();
        logic [7:0] hr;
        logic [7:0] spo2;
        hr = 8'($urandom_range(255));
        spo2 = 8'($urandom_range(255));
        case ($urandom_range(9))
            0: begin
                hr = '0;
                spo2 = '0;
            end
            1: hr = '0;
            2: spo2 = '0;
            default: ;
        endcase
        send_fields(pick_sample(sys_bounds), pick_sample(dia_bounds), hr, spo2);
    endtask

    task automatic test_default_windows();
        logic [7:0] sys_seq[12] = '{100, 140, 120, 140, 140, 101, 139, 100, 110,
                                    125, 125, 125};
        logic [7:0] dia_seq[12] = '{70, 100, 85, 71, 71, 99, 100, 70, 90,
                                    80, 95, 88};
        send_fields(8'd0, 8'd0, 8'd0, 8'd0);
        send_fields(8'd255, 8'd255, 8'd255, 8'd255);
        send_fields(8'd99, 8'd69, 8'd0, 8'd1);
        send_fields(8'd141, 8'd101, 8'd1, 8'd0);
        for (int i = 0; i < 12; i++)
            send_fields(sys_seq[i], dia_seq[i], 8'd72, 8'd97);
        send_fields(8'd130, 8'd90, 8'd0, 8'd0);
        send_fields(8'd130, 8'd90, 8'd80, 8'd0);
        send_fields(8'd0, 8'd255, 8'd0, 8'd98);
        send_fields(8'd255, 8'd0, 8'd170, 8'd85);
        wait_drained();
    endtask

    task automatic test_wide_windows();
        set_windows(8'd0, 8'd255, 8'd0, 8'd255);
        for (int i = 0; i < 60; i++)
            send_random_item();
        wait_drained();
    endtask

    task automatic test_narrow_windows();
        set_windows(8'd255, 8'd255, 8'd0, 8'd0);
        for (int i = 0; i < 15; i++)
            send_fields(($urandom_range(4) == 0) ? 8'd254 : 8'd255,
                        ($urandom_range(4) == 0) ? 8'd1 : 8'd0, 8'd60, 8'd99);
        set_windows(8'd0, 8'd0, 8'd255, 8'd255);
        for (int i = 0; i < 15; i++)
            send_fields(($urandom_range(4) == 0) ? 8'd1 : 8'd0,
                        ($urandom_range(4) == 0) ? 8'd254 : 8'd255, 8'd0, 8'd95);
        // low above high: nothing gets through on either channel
        set_windows(8'd200, 8'd10, 8'd255, 8'd0);
        for (int i = 0; i < 10; i++)
            send_random_item();
        wait_drained();
    endtask

    task automatic test_random(input int send_pct, input int recv_pct,
                               input int settings, input int per_setting);
        t_bounds sb;
        t_bounds db;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int s = 0; s < settings; s++) begin
            sb = pick_bounds();
            db = pick_bounds();
            set_windows(sb.low, sb.high, db.low, db.high);
            for (int i = 0; i < per_setting; i++)
                send_random_item();
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_windows(8'd90, 8'd160, 8'd50, 8'd110);
        stall_req <= ~stall_req;
        for (int i = 0; i < 40; i++)
            send_random_item();
        wait_drained();
    endtask

    initial begin
        sys_bounds = '{low: SYS_LOW_RST, high: SYS_HIGH_RST};
        dia_bounds = '{low: DIA_LOW_RST, high: DIA_HIGH_RST};
        sys_ch = '0;
        dia_ch = '0;
        send_idle_pct = 11;
        recv_idle_pct = 82;
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_windows();
        test_wide_windows();
        test_narrow_windows();
        test_random(11, 82, 4, 50);
        test_random(82, 11, 4, 50);
        test_random(0, 0, 5, 40);
        test_backpressure();

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #8000000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
